// ----- sv/rvx_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rvx_pkg
// Shared types, constants and helpers of the RV32I execute block.
// ----------------------------------------------------------------------------
package rvx_pkg;

    localparam int XLEN      = 32;
    localparam int IDX_W     = 10;
    localparam int MADDR_W   = 10;
    localparam int MEM_DEPTH = 1024;
    localparam int RF_DEPTH  = 32;
    localparam int RADDR_W   = 5;
    localparam int CMD_W     = 6;
    localparam int S_DATA_W  = 64;
    localparam int M_DATA_W  = 96;

    localparam logic [CMD_W-1:0] CMD_ADDI  = 6'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 6'd1;
    localparam logic [CMD_W-1:0] CMD_SUB   = 6'd2;
    localparam logic [CMD_W-1:0] CMD_SLT   = 6'd3;
    localparam logic [CMD_W-1:0] CMD_SLTI  = 6'd4;
    localparam logic [CMD_W-1:0] CMD_SLTIU = 6'd5;
    localparam logic [CMD_W-1:0] CMD_SLTU  = 6'd6;
    localparam logic [CMD_W-1:0] CMD_XORI  = 6'd7;
    localparam logic [CMD_W-1:0] CMD_XOR   = 6'd8;
    localparam logic [CMD_W-1:0] CMD_ORI   = 6'd9;
    localparam logic [CMD_W-1:0] CMD_OR    = 6'd10;
    localparam logic [CMD_W-1:0] CMD_ANDI  = 6'd11;
    localparam logic [CMD_W-1:0] CMD_SLLI  = 6'd12;
    localparam logic [CMD_W-1:0] CMD_SLL   = 6'd13;
    localparam logic [CMD_W-1:0] CMD_SRLI  = 6'd14;
    localparam logic [CMD_W-1:0] CMD_SRL   = 6'd15;
    localparam logic [CMD_W-1:0] CMD_SRAI  = 6'd16;
    localparam logic [CMD_W-1:0] CMD_SRA   = 6'd17;
    localparam logic [CMD_W-1:0] CMD_AND   = 6'd18;
    localparam logic [CMD_W-1:0] CMD_LUI   = 6'd19;
    localparam logic [CMD_W-1:0] CMD_AUIPC = 6'd20;
    localparam logic [CMD_W-1:0] CMD_JAL   = 6'd21;
    localparam logic [CMD_W-1:0] CMD_JALR  = 6'd22;
    localparam logic [CMD_W-1:0] CMD_BEQ   = 6'd23;
    localparam logic [CMD_W-1:0] CMD_BNE   = 6'd24;
    localparam logic [CMD_W-1:0] CMD_BLT   = 6'd25;
    localparam logic [CMD_W-1:0] CMD_BGE   = 6'd26;
    localparam logic [CMD_W-1:0] CMD_BLTU  = 6'd27;
    localparam logic [CMD_W-1:0] CMD_BGEU  = 6'd28;
    localparam logic [CMD_W-1:0] CMD_LB    = 6'd29;
    localparam logic [CMD_W-1:0] CMD_LH    = 6'd30;
    localparam logic [CMD_W-1:0] CMD_LW    = 6'd31;
    localparam logic [CMD_W-1:0] CMD_LBU   = 6'd32;
    localparam logic [CMD_W-1:0] CMD_LHU   = 6'd33;
    localparam logic [CMD_W-1:0] CMD_SB    = 6'd34;
    localparam logic [CMD_W-1:0] CMD_SH    = 6'd35;
    localparam logic [CMD_W-1:0] CMD_SW    = 6'd36;
    localparam logic [CMD_W-1:0] CMD_ECALL = 6'd37;

    typedef struct packed {
        logic                 wr;
        logic [XLEN-1:0]      val;
        logic [IDX_W-1:0]     next;
        logic                 mem_op;
        logic                 is_load;
        logic                 mw;
        logic [XLEN-1:0]      mword;
        logic [MADDR_W-1:0]   maddr;
        logic                 halt_set;
    } exec_t;

    function automatic logic [XLEN-1:0] load_extract(input logic [CMD_W-1:0] cmd,
                                                     input logic [XLEN-1:0] d);
        logic [XLEN-1:0] r;
        case (cmd)
            CMD_LB:  r = {{24{d[7]}}, d[7:0]};
            CMD_LH:  r = {{16{d[15]}}, d[15:0]};
            CMD_LBU: r = {24'd0, d[7:0]};
            CMD_LHU: r = {16'd0, d[15:0]};
            default: r = d;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- sv/rv32i_instruction_executor.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rv32i_instruction_executor
// Executes pre-decoded RV32I instructions against a register file and a
// word-addressed data memory, one result word per instruction word.
// ----------------------------------------------------------------------------
// Input word (s_tdata) carries one decoded instruction; output word (m_tdata)
// reports next index, its byte address, register write, memory write, halt.
// cfg_we/cfg_wdata set base_address; write only while the block is idle.
// Flow: the accept edge registers both source register reads; ST_EX then
// executes, and a non-load word completes there once the output register
// is free. A load goes on to ST_MEM for the registered data memory read.
// A new word is taken on the completing edge, so non-load words run at one
// word per cycle with register forwarding while the output does not stall.
// Result is held in an output register; while m_tready is low one finished
// result waits there and execution of the next word stalls at completion.
// Reset: register file, index and halt flag clear at once; data memory is
// cleared by a pass over all 1024 words during which s_tready stays low.
// After ECALL every word reports the held index with halted set.
// ----------------------------------------------------------------------------
module rv32i_instruction_executor (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [31:0]                     cfg_wdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // command[5:0] dest_reg[10:6] src1_reg[15:11] src2_reg[20:16]
    // immediate[52:21] target_index[62:53]
    input  wire logic [rvx_pkg::S_DATA_W-1:0]    s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // next_index[9:0] next_address[41:10] reg_written[42] written_reg[47:43]
    // written_value[79:48] mem_written[80] mem_addr[90:81] halted[91]
    output logic [rvx_pkg::M_DATA_W-1:0]         m_tdata
);
    import rvx_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EX   = 2'd1;
    localparam logic [1:0] ST_MEM  = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [XLEN-1:0]     base_reg;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                halt_reg, halt_next;
    logic [CMD_W-1:0]    cmd_reg;
    logic [RADDR_W-1:0]  rd_reg;
    logic [XLEN-1:0]     imm_reg;
    logic [IDX_W-1:0]    tgt_reg;
    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;

    logic                s_acc, out_ok, done, clearing, rf_we, wr_fin;
    logic [XLEN-1:0]     a, b, dq, val_fin, nxt_addr;
    exec_t               ex;

    rvx_regfile u_rf (
        .aclk   (aclk),
        .aresetn(aresetn),
        .re     (s_acc),
        .raddr1 (s_tdata[15:11]),
        .raddr2 (s_tdata[20:16]),
        .we     (rf_we),
        .waddr  (rd_reg),
        .wdata  (val_fin),
        .rdata1 (a),
        .rdata2 (b)
    );

    rvx_alu u_alu (
        .cmd (cmd_reg),
        .a   (a),
        .b   (b),
        .imm (imm_reg),
        .tgt (tgt_reg),
        .idx (idx_reg),
        .base(base_reg),
        .halt(halt_reg),
        .res (ex)
    );

    rvx_dmem u_dmem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .re      (state_reg == ST_EX),
        .raddr   (ex.maddr),
        .we      (state_reg == ST_EX && ex.mw),
        .waddr   (ex.maddr),
        .wdata   (ex.mword),
        .rdata   (dq),
        .clearing(clearing)
    );

    assign out_ok   = !m_valid_reg || m_tready;
    assign done     = ((state_reg == ST_EX && !ex.is_load) || state_reg == ST_MEM) && out_ok;
    assign s_tready = !clearing && (state_reg == ST_IDLE || done);
    assign s_acc    = s_tvalid && s_tready;

    assign val_fin  = ex.is_load ? load_extract(cmd_reg, dq) : ex.val;
    assign wr_fin   = ex.wr && (rd_reg != '0);
    assign rf_we    = done && wr_fin;
    assign idx_next = ex.next;
    assign halt_next = halt_reg || ex.halt_set;
    assign nxt_addr = base_reg + {{(XLEN-IDX_W-2){1'b0}}, idx_next, 2'b00};

    always_comb begin
        m_data_next = {4'd0, halt_next, ex.maddr, ex.mw,
                       wr_fin ? val_fin : {XLEN{1'b0}},
                       wr_fin ? rd_reg : {RADDR_W{1'b0}}, wr_fin,
                       nxt_addr, idx_next};
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_acc) state_next = ST_EX;
            ST_EX: begin
                if (ex.is_load) begin
                    state_next = ST_MEM;
                end else if (done) begin
                    state_next = s_acc ? ST_EX : ST_IDLE;
                end
            end
            ST_MEM:  if (done) state_next = s_acc ? ST_EX : ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            base_reg    <= '0;
            idx_reg     <= '0;
            halt_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                base_reg <= cfg_wdata;
            end
            if (done) begin
                idx_reg     <= idx_next;
                halt_reg    <= halt_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            cmd_reg <= s_tdata[5:0];
            rd_reg  <= s_tdata[10:6];
            imm_reg <= s_tdata[52:21];
            tgt_reg <= s_tdata[62:53];
        end
        if (done) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
`default_nettype wire

// ----- sv/rvx_regfile.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rvx_regfile
// 32 x 32 register file, two registered reads, one write, valid bits for
// reset-to-zero and same-edge write forwarding.
// ----------------------------------------------------------------------------
module rvx_regfile (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           re,
    input  wire logic [rvx_pkg::RADDR_W-1:0]    raddr1,
    input  wire logic [rvx_pkg::RADDR_W-1:0]    raddr2,
    input  wire logic                           we,
    input  wire logic [rvx_pkg::RADDR_W-1:0]    waddr,
    input  wire logic [rvx_pkg::XLEN-1:0]       wdata,
    output logic [rvx_pkg::XLEN-1:0]            rdata1,
    output logic [rvx_pkg::XLEN-1:0]            rdata2
);
    import rvx_pkg::*;

    logic [XLEN-1:0]     mem [RF_DEPTH];
    logic [RF_DEPTH-1:0] valid_reg;
    logic [XLEN-1:0]     q1_reg, q2_reg, fwd_data_reg;
    logic                v1_reg, v2_reg, f1_reg, f2_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            q1_reg       <= mem[raddr1];
            q2_reg       <= mem[raddr2];
            fwd_data_reg <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            f1_reg    <= 1'b0;
            f2_reg    <= 1'b0;
        end else begin
            if (we) begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re) begin
                v1_reg <= valid_reg[raddr1];
                v2_reg <= valid_reg[raddr2];
                f1_reg <= we && (waddr == raddr1);
                f2_reg <= we && (waddr == raddr2);
            end
        end
    end

    assign rdata1 = f1_reg ? fwd_data_reg : (v1_reg ? q1_reg : '0);
    assign rdata2 = f2_reg ? fwd_data_reg : (v2_reg ? q2_reg : '0);

endmodule
`default_nettype wire

// ----- sv/rvx_dmem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rvx_dmem
// Word-addressed data memory, registered read, zero-clearing pass after reset.
// ----------------------------------------------------------------------------
module rvx_dmem (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           re,
    input  wire logic [rvx_pkg::MADDR_W-1:0]    raddr,
    input  wire logic                           we,
    input  wire logic [rvx_pkg::MADDR_W-1:0]    waddr,
    input  wire logic [rvx_pkg::XLEN-1:0]       wdata,
    output logic [rvx_pkg::XLEN-1:0]            rdata,
    output logic                                clearing
);
    import rvx_pkg::*;

    logic [XLEN-1:0]  mem [MEM_DEPTH];
    logic [MADDR_W:0] clr_reg, clr_next;

    assign clearing = !clr_reg[MADDR_W];
    assign clr_next = clr_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (clearing) begin
            clr_reg <= clr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (clearing) begin
            mem[clr_reg[MADDR_W-1:0]] <= '0;
        end else if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ----- sv/rvx_alu.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rvx_alu
// Execute logic: ALU, compare, branch, jump target and address generation.
// ----------------------------------------------------------------------------
module rvx_alu (
    input  wire logic [rvx_pkg::CMD_W-1:0]   cmd,
    input  wire logic [rvx_pkg::XLEN-1:0]    a,
    input  wire logic [rvx_pkg::XLEN-1:0]    b,
    input  wire logic [rvx_pkg::XLEN-1:0]    imm,
    input  wire logic [rvx_pkg::IDX_W-1:0]   tgt,
    input  wire logic [rvx_pkg::IDX_W-1:0]   idx,
    input  wire logic [rvx_pkg::XLEN-1:0]    base,
    input  wire logic                        halt,
    output rvx_pkg::exec_t                   res
);
    import rvx_pkg::*;

    logic [XLEN-1:0]  pc_addr, sum_ai, jalr_off;
    logic [4:0]       shi, shb;

    assign pc_addr  = base + {{(XLEN-IDX_W-2){1'b0}}, idx, 2'b00};
    assign sum_ai   = a + imm;
    assign jalr_off = {sum_ai[XLEN-1:1], 1'b0} - base;
    assign shi      = imm[4:0];
    assign shb      = b[4:0];

    always_comb begin
        res          = '0;
        res.next     = idx + 1'b1;
        res.maddr    = sum_ai[MADDR_W-1:0];
        if (halt) begin
            res.next  = idx;
            res.maddr = '0;
        end else begin
            case (cmd)
                CMD_ADDI:  begin res.val = sum_ai; res.wr = 1'b1; end
                CMD_ADD:   begin res.val = a + b; res.wr = 1'b1; end
                CMD_SUB:   begin res.val = a - b; res.wr = 1'b1; end
                CMD_SLT:   begin
                    res.val = {31'd0, $signed(a) < $signed(b)}; res.wr = 1'b1;
                end
                CMD_SLTI:  begin
                    res.val = {31'd0, $signed(a) < $signed(imm)}; res.wr = 1'b1;
                end
                CMD_SLTIU: begin res.val = {31'd0, a < imm}; res.wr = 1'b1; end
                CMD_SLTU:  begin res.val = {31'd0, a < b}; res.wr = 1'b1; end
                CMD_XORI:  begin res.val = a ^ imm; res.wr = 1'b1; end
                CMD_XOR:   begin res.val = a ^ b; res.wr = 1'b1; end
                CMD_ORI:   begin res.val = a | imm; res.wr = 1'b1; end
                CMD_OR:    begin res.val = a | b; res.wr = 1'b1; end
                CMD_ANDI:  begin res.val = a & imm; res.wr = 1'b1; end
                CMD_SLLI:  begin res.val = a << shi; res.wr = 1'b1; end
                CMD_SLL:   begin res.val = a << shb; res.wr = 1'b1; end
                CMD_SRLI:  begin res.val = a >> shi; res.wr = 1'b1; end
                CMD_SRL:   begin res.val = a >> shb; res.wr = 1'b1; end
                CMD_SRAI:  begin res.val = $unsigned($signed(a) >>> shi); res.wr = 1'b1; end
                CMD_SRA:   begin res.val = $unsigned($signed(a) >>> shb); res.wr = 1'b1; end
                CMD_AND:   begin res.val = a & b; res.wr = 1'b1; end
                CMD_LUI:   begin res.val = {imm[19:0], 12'd0}; res.wr = 1'b1; end
                CMD_AUIPC: begin
                    res.val = pc_addr + {imm[19:0], 12'd0}; res.wr = 1'b1;
                end
                CMD_JAL:   begin
                    res.val = pc_addr + 32'd4; res.wr = 1'b1; res.next = tgt;
                end
                CMD_JALR:  begin
                    res.val  = pc_addr + 32'd4; res.wr = 1'b1;
                    res.next = jalr_off[IDX_W+1:2];
                end
                CMD_BEQ:   if (a == b) res.next = tgt;
                CMD_BNE:   if (a != b) res.next = tgt;
                CMD_BLT:   if ($signed(a) < $signed(b)) res.next = tgt;
                CMD_BGE:   if ($signed(a) >= $signed(b)) res.next = tgt;
                CMD_BLTU:  if (a < b) res.next = tgt;
                CMD_BGEU:  if (a >= b) res.next = tgt;
                CMD_LB, CMD_LH, CMD_LW, CMD_LBU, CMD_LHU: begin
                    res.mem_op = 1'b1; res.is_load = 1'b1; res.wr = 1'b1;
                end
                CMD_SB:    begin
                    res.mem_op = 1'b1; res.mw = 1'b1; res.mword = {{24{b[7]}}, b[7:0]};
                end
                CMD_SH:    begin
                    res.mem_op = 1'b1; res.mw = 1'b1; res.mword = {{16{b[15]}}, b[15:0]};
                end
                CMD_SW:    begin res.mem_op = 1'b1; res.mw = 1'b1; res.mword = b; end
                CMD_ECALL: begin res.halt_set = 1'b1; res.next = idx; end
                default:   ;
            endcase
            if (!res.mem_op) begin
                res.maddr = '0;
            end
        end
    end

endmodule
`default_nettype wire

// ----- sv/rvx_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rvx_checker
// Port-level checks of the RV32I execute block.
// ----------------------------------------------------------------------------
module rvx_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [rvx_pkg::M_DATA_W-1:0]   m_tdata
);
    logic halt_seen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            halt_seen_reg <= 1'b0;
        end else if (m_tvalid && m_tready && m_tdata[91]) begin
            halt_seen_reg <= 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && halt_seen_reg |-> m_tdata[91] && !m_tdata[42] && !m_tdata[80])
        else $error("activity after halt");

    a_no_reg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[42] |-> m_tdata[79:43] == '0)
        else $error("register fields set without a write");

    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[80] |-> !m_tdata[42])
        else $error("store also wrote a register");

endmodule

bind rv32i_instruction_executor rvx_checker u_rvx_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);
`default_nettype wire

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// RV32I instruction executor testbench
// Drives decoded instruction words, predicts register file, data memory,
// index and halt state, and checks every result word in order.
// ----------------------------------------------------------------------------
import rvx_pkg::*;

typedef struct packed {
    logic        hlt;
    logic [9:0]  maddr;
    logic        mwr;
    logic [31:0] rval;
    logic [4:0]  rnum;
    logic        rwr;
    logic [31:0] naddr;
    logic [9:0]  nidx;
} exec_res_t;

class exec_scoreboard;
    logic [31:0] base;
    logic [31:0] regs[32];
    logic [31:0] dmem[1024];
    logic [9:0]  pc_idx;
    bit          halted;
    exec_res_t   pending[$];
    int          errors;

    function void clear();
        base = 0;
        pc_idx = 0;
        halted = 0;
        errors = 0;
        foreach (regs[i]) regs[i] = 0;
        foreach (dmem[i]) dmem[i] = 0;
    endfunction

    function void note_instr(logic [5:0] cmd, logic [4:0] rd, logic [4:0] r1,
                             logic [4:0] r2, logic [31:0] imm, logic [9:0] tgt);
        logic [31:0] a, b, v, pca, w;
        logic [9:0] nx, ma;
        bit wr, mw, mop;
        exec_res_t e;
        a = regs[r1]; b = regs[r2];
        pca = base + {pc_idx, 2'b00};
        nx = pc_idx + 10'd1;
        ma = 10'(a + imm);
        v = 0; wr = 0; mw = 0; mop = 0;
        if (!halted) begin
            case (cmd)
                CMD_ADDI:  begin v = a + imm; wr = 1; end
                CMD_ADD:   begin v = a + b; wr = 1; end
                CMD_SUB:   begin v = a - b; wr = 1; end
                CMD_SLT:   begin v = {31'd0, $signed(a) < $signed(b)}; wr = 1; end
                CMD_SLTI:  begin v = {31'd0, $signed(a) < $signed(imm)}; wr = 1; end
                CMD_SLTIU: begin v = {31'd0, a < imm}; wr = 1; end
                CMD_SLTU:  begin v = {31'd0, a < b}; wr = 1; end
                CMD_XORI:  begin v = a ^ imm; wr = 1; end
                CMD_XOR:   begin v = a ^ b; wr = 1; end
                CMD_ORI:   begin v = a | imm; wr = 1; end
                CMD_OR:    begin v = a | b; wr = 1; end
                CMD_ANDI:  begin v = a & imm; wr = 1; end
                CMD_SLLI:  begin v = a << imm[4:0]; wr = 1; end
                CMD_SLL:   begin v = a << b[4:0]; wr = 1; end
                CMD_SRLI:  begin v = a >> imm[4:0]; wr = 1; end
                CMD_SRL:   begin v = a >> b[4:0]; wr = 1; end
                CMD_SRAI:  begin v = $signed(a) >>> imm[4:0]; wr = 1; end
                CMD_SRA:   begin v = $signed(a) >>> b[4:0]; wr = 1; end
                CMD_AND:   begin v = a & b; wr = 1; end
                CMD_LUI:   begin v = imm << 12; wr = 1; end
                CMD_AUIPC: begin v = pca + (imm << 12); wr = 1; end
                CMD_JAL:   begin v = pca + 4; wr = 1; nx = tgt; end
                CMD_JALR: begin
                    v = pca + 4; wr = 1;
                    w = ((a + imm) & ~32'd1) - base;
                    nx = w[11:2];
                end
                CMD_BEQ:  if (a == b) nx = tgt;
                CMD_BNE:  if (a != b) nx = tgt;
                CMD_BLT:  if ($signed(a) < $signed(b)) nx = tgt;
                CMD_BGE:  if ($signed(a) >= $signed(b)) nx = tgt;
                CMD_BLTU: if (a < b) nx = tgt;
                CMD_BGEU: if (a >= b) nx = tgt;
                CMD_LB, CMD_LH, CMD_LW, CMD_LBU, CMD_LHU: begin
                    mop = 1; wr = 1; w = dmem[ma];
                    case (cmd)
                        CMD_LB:  v = {{24{w[7]}}, w[7:0]};
                        CMD_LH:  v = {{16{w[15]}}, w[15:0]};
                        CMD_LBU: v = {24'd0, w[7:0]};
                        CMD_LHU: v = {16'd0, w[15:0]};
                        default: v = w;
                    endcase
                end
                CMD_SB, CMD_SH, CMD_SW: begin
                    mop = 1; mw = 1;
                    if (cmd == CMD_SB) w = {{24{b[7]}}, b[7:0]};
                    else if (cmd == CMD_SH) w = {{16{b[15]}}, b[15:0]};
                    else w = b;
                    dmem[ma] = w;
                end
                CMD_ECALL: begin halted = 1; nx = pc_idx; end
                default: ;
            endcase
            pc_idx = nx;
        end
        if (rd == 0) wr = 0;
        if (wr) regs[rd] = v;
        e.nidx = pc_idx;
        e.naddr = base + {pc_idx, 2'b00};
        e.rwr = wr;
        e.rnum = wr ? rd : 5'd0;
        e.rval = wr ? v : 32'd0;
        e.mwr = mw;
        e.maddr = mop ? ma : 10'd0;
        e.hlt = halted;
        pending = {pending, e};
    endfunction

    function void report(string what, logic [31:0] got, logic [31:0] exp);
        errors++;
        $display("mismatch %s: got %h expected %h", what, got, exp);
    endfunction

    function void check_result(logic [95:0] d);
        exec_res_t e, g;
        if (pending.size() == 0) begin
            report("unexpected word", d[31:0], 0);
            return;
        end
        e = pending.pop_front();
        g = d[91:0];
        if (g.nidx != e.nidx) report("next_index", g.nidx, e.nidx);
        if (g.naddr != e.naddr) report("next_address", g.naddr, e.naddr);
        if (g.rwr != e.rwr) report("reg_written", g.rwr, e.rwr);
        if (g.rnum != e.rnum) report("written_reg", g.rnum, e.rnum);
        if (g.rval != e.rval) report("written_value", g.rval, e.rval);
        if (g.mwr != e.mwr) report("mem_written", g.mwr, e.mwr);
        if (g.maddr != e.maddr) report("mem_addr", g.maddr, e.maddr);
        if (g.hlt != e.hlt) report("halted", g.hlt, e.hlt);
    endfunction
endclass

module testbench;
    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic [31:0] cfg_wdata = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [63:0] s_tdata = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [95:0] m_tdata;

    exec_scoreboard sb = new();
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_cycles = 0;
    longint cycles = 0;

    rv32i_instruction_executor u_top (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 600000) begin
            $display("** rv32i_instruction_executor: FAILED **");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_word(logic [5:0] cmd, logic [4:0] rd, logic [4:0] r1,
                             logic [4:0] r2, logic [31:0] imm, logic [9:0] tgt);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {1'b0, tgt, imm, r2, r1, rd, cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_instr(cmd, rd, r1, r2, imm, tgt);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_base(logic [31:0] v);
        cfg_we <= 1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 0;
        sb.base = v;
    endtask

    function automatic logic [31:0] rand_imm();
        case ($urandom_range(4))
            0: return $urandom_range(31);
            1: return 32'h0 - $urandom_range(16);
            2: return $urandom_range(1023);
            3: return {$urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff};
            default: return $urandom;
        endcase
    endfunction

    task automatic rand_word(bit allow_ecall);
        logic [5:0] c;
        c = 6'($urandom_range(allow_ecall ? 37 : 36));
        if ($urandom_range(15) == 0) c = 6'($urandom_range(63, 38));
        send_word(c, 5'($urandom), 5'($urandom), 5'($urandom), rand_imm(),
                  10'($urandom));
    endtask

    initial begin
        sb.clear();
        repeat (12) @(posedge aclk);
        aresetn <= 1;

        // directed
        set_base(32'h0000_1000);
        send_word(CMD_ADDI, 1, 0, 0, 32'h7fff_ffff, 0);
        send_word(CMD_ADDI, 2, 0, 0, 32'h8000_0000, 0);
        send_word(CMD_ADDI, 3, 0, 0, 32'hffff_ffff, 0);
        send_word(CMD_ADD, 4, 1, 3, 0, 0);
        send_word(CMD_SUB, 5, 2, 1, 0, 0);
        send_word(CMD_SLT, 6, 2, 1, 0, 0);
        send_word(CMD_SLTIU, 7, 1, 0, 32'hffff_ffff, 0);
        send_word(CMD_SLTU, 8, 1, 3, 0, 0);
        send_word(CMD_SRA, 9, 2, 3, 0, 0);
        send_word(CMD_SRAI, 10, 3, 0, 32'h0000_0021, 0);
        send_word(CMD_SLL, 11, 3, 1, 0, 0);
        send_word(CMD_LUI, 12, 0, 0, 32'hfffff, 0);
        send_word(CMD_AUIPC, 13, 0, 0, 32'h1, 0);
        send_word(CMD_ADDI, 0, 1, 0, 5, 0);
        send_word(CMD_SB, 0, 0, 3, 32'd1023, 0);
        send_word(CMD_LBU, 14, 0, 0, 32'd1023, 0);
        send_word(CMD_SH, 0, 1, 2, 32'd5, 0);
        send_word(CMD_LH, 15, 1, 0, 32'd5, 0);
        send_word(CMD_BGE, 0, 1, 1, 0, 10'd1023);
        send_word(CMD_BLTU, 0, 1, 3, 0, 10'd7);
        send_word(CMD_JAL, 16, 0, 0, 0, 10'd500);
        send_word(CMD_JALR, 17, 13, 0, 32'h3, 0);
        send_word(6'd63, 0, 0, 0, 0, 0);
        send_word(CMD_ADDI, 1, 0, 0, 32'd9, 0);
        drain();

        // random phases; ECALL only in the last one so most work runs live
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  set_base(32'h0); end
                1: begin idle_pct = 65; stall_pct = 0;  set_base(32'hffff_fffc); end
                2: begin idle_pct = 0;  stall_pct = 65; set_base($urandom); end
                3: begin idle_pct = 13; stall_pct = 13; set_base(32'h8000_0000); end
                default: begin idle_pct = 13; stall_pct = 13; set_base($urandom); end
            endcase
            if (ph == 2) begin
                hold_cycles = 60;
                for (int i = 0; i < 20; i++) rand_word(0);
                drain();
            end
            for (int i = 0; i < 125; i++) rand_word(ph == 4 && i > 100);
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("** rv32i_instruction_executor: PASSED **");
        else
            $display("** rv32i_instruction_executor: FAILED **");
        $finish;
    end
endmodule

// ----- files.f -----
sv/rvx_pkg.sv
sv/rvx_regfile.sv
sv/rvx_dmem.sv
sv/rvx_alu.sv
sv/rv32i_instruction_executor.sv
sv/rvx_checker.sv
dv/testbench.sv
